[sv/bra_pkg.sv]
// shared types and constants for the bitmap range allocator
package bra_pkg;

  // payload widths of the command and result beats
  localparam int CMD_W   = 2;
  localparam int RANGE_W = 16;
  localparam int INDEX_W = 15;

  typedef logic [CMD_W-1:0] cmd_t;

  // command codes
  localparam cmd_t CMD_SET   = 2'd0;
  localparam cmd_t CMD_CLR   = 2'd1;
  localparam cmd_t CMD_ALLOC = 2'd2;

endpackage

[sv/bra_if.sv]
// valid/ready channel interfaces for commands and results
interface bra_cmd_if import bra_pkg::*; ();
  logic                valid;
  logic                ready;
  cmd_t                command;
  logic [RANGE_W-1:0]  range_start;
  logic [RANGE_W-1:0]  range_end;

  modport source (output valid, command, range_start, range_end, input ready);
  modport sink   (input valid, command, range_start, range_end, output ready);
endinterface

interface bra_res_if import bra_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                found;
  logic [INDEX_W-1:0]  alloc_index;

  modport source (output valid, found, alloc_index, input ready);
  modport sink   (input valid, found, alloc_index, output ready);
endinterface

[sv/bra_ram.sv]
// generic simple dual-port ram with registered read
module bra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [ADDR_W-1:0]       wr_addr,
  input  logic [WIDTH-1:0]        wr_data,
  input  logic                    rd_en,
  input  logic [ADDR_W-1:0]       rd_addr,
  output logic [WIDTH-1:0]        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[sv/bitmap_range_allocator.sv]
// free-space bitmap allocator: range set/clear and first-fit allocate over a word ram
//
//   channel  | dir | beat contents                       | handshake
//   in_cmd   | in  | command, range_start, range_end     | valid/ready
//   out_res  | out | found, alloc_index                  | valid/ready
//
// range commands sweep words 0 .. ceil(min(end,MAP_BITS)/WORD_BITS)-1, one word per cycle
// through the ram's read port, with each word written back in the cycle after its read.
// allocate sweeps from word 0 until the first word with a free bit, or over all
// MAP_WORDS words on a full map. empty ranges and unused codes skip the sweep and
// go straight to the finish step. the next beat is taken only in the idle state,
// after the previous command has finished.
// after reset a clearing pass writes zeros to all MAP_WORDS words (1024 words by default)
// before the first command beat is taken.
// a finished result waits in the output register; the next command is taken meanwhile,
// and its own result stalls in the finish step until the held beat is taken.
module bitmap_range_allocator import bra_pkg::*; #(
  parameter int MAP_BITS  = 32768,
  parameter int WORD_BITS = 32
) (
  input  logic   clk,
  input  logic   rst_n,
  bra_cmd_if.sink   in_cmd,
  bra_res_if.source out_res
);

  localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int WCNT_W    = $clog2(MAP_WORDS + 1);
  localparam int BASE_W    = $clog2(MAP_WORDS * WORD_BITS + 1);
  localparam int CW        = ((BASE_W > RANGE_W) ? BASE_W : RANGE_W) + 1;
  localparam int BIDX_W    = $clog2(WORD_BITS);
  localparam int BC_W      = BIDX_W + 1;
  localparam int IXF_W     = (BASE_W > INDEX_W) ? BASE_W : INDEX_W;

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_SWEEP  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [WCNT_W-1:0]    clr_addr_r, clr_addr_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic [CW-1:0]        lo_r, lo_nxt;
  logic [CW-1:0]        hi_r, hi_nxt;
  logic [WCNT_W-1:0]    iss_w_r, iss_w_nxt;
  logic [BASE_W-1:0]    iss_base_r, iss_base_nxt;
  logic                 ret_valid_r, ret_valid_nxt;
  logic [WADDR_W-1:0]   ret_w_r, ret_w_nxt;
  logic [BASE_W-1:0]    ret_base_r, ret_base_nxt;
  logic                 res_found_r, res_found_nxt;
  logic [INDEX_W-1:0]   res_index_r, res_index_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_found_r, out_found_nxt;
  logic [INDEX_W-1:0]   out_index_r, out_index_nxt;

  logic                 wr_en, rd_en;
  logic [WADDR_W-1:0]   wr_addr, rd_addr;
  logic [WORD_BITS-1:0] wr_data, rd_data;

  logic                 accept, issue, hit, load_out;
  logic [CW-1:0]        in_lo_x, in_hi_x, in_hi_eff, map_x, base_x, lo_diff, hi_diff;
  logic [BC_W-1:0]      lo_c, hi_c;
  logic [WORD_BITS-1:0] mask, avail, lowest;
  logic [BIDX_W-1:0]    enc;
  logic [IXF_W-1:0]     hit_index;

  // usage map storage
  bra_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign accept   = in_cmd.valid && in_cmd.ready;
  assign load_out = (state_r == ST_FINISH) && (!out_valid_r || out_res.ready);

  // clip the incoming range to the map
  always_comb begin
    in_lo_x   = CW'(in_cmd.range_start);
    in_hi_x   = CW'(in_cmd.range_end);
    map_x     = CW'(MAP_BITS);
    in_hi_eff = (in_hi_x > map_x) ? map_x : in_hi_x;
  end

  // bit mask of the returned word that lies inside [lo, hi)
  always_comb begin
    base_x  = CW'(ret_base_r);
    lo_diff = lo_r - base_x;
    hi_diff = hi_r - base_x;
    if (lo_r <= base_x) begin
      lo_c = '0;
    end else if (lo_diff >= CW'(WORD_BITS)) begin
      lo_c = BC_W'(WORD_BITS);
    end else begin
      lo_c = lo_diff[BC_W-1:0];
    end
    if (hi_r <= base_x) begin
      hi_c = '0;
    end else if (hi_diff >= CW'(WORD_BITS)) begin
      hi_c = BC_W'(WORD_BITS);
    end else begin
      hi_c = hi_diff[BC_W-1:0];
    end
    for (int j = 0; j < WORD_BITS; j++) begin
      mask[j] = (BC_W'(j) >= lo_c) && (BC_W'(j) < hi_c);
    end
  end

  // first free bit of the returned word
  always_comb begin
    avail  = ~rd_data & mask;
    lowest = avail & (~avail + WORD_BITS'(1));
    enc    = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (lowest[j]) begin
        enc = enc | BIDX_W'(j);
      end
    end
    hit_index = IXF_W'(ret_base_r) + IXF_W'(enc);
    hit       = (state_r == ST_SWEEP) && ret_valid_r && (cmd_r == CMD_ALLOC) && (avail != '0);
  end

  // read issue: one word per cycle until past the range or the map, or until an allocate hits
  assign issue = (state_r == ST_SWEEP) && !hit && (iss_w_r < WCNT_W'(MAP_WORDS)) &&
                 (CW'(iss_base_r) < hi_r);

  assign rd_en   = issue;
  assign rd_addr = iss_w_r[WADDR_W-1:0];

  // write port: clearing pass or read-modify-write of the returned word
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ret_w_r;
    wr_data = rd_data;
    if (state_r == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r[WADDR_W-1:0];
      wr_data = '0;
    end else if ((state_r == ST_SWEEP) && ret_valid_r) begin
      case (cmd_r)
        CMD_SET: begin
          wr_en   = 1'b1;
          wr_data = rd_data | mask;
        end
        CMD_CLR: begin
          wr_en   = 1'b1;
          wr_data = rd_data & ~mask;
        end
        CMD_ALLOC: begin
          wr_en   = hit;
          wr_data = rd_data | lowest;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  assign in_cmd.ready = (state_r == ST_IDLE);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    cmd_nxt       = cmd_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    iss_w_nxt     = iss_w_r;
    iss_base_nxt  = iss_base_r;
    ret_valid_nxt = issue;
    ret_w_nxt     = iss_w_r[WADDR_W-1:0];
    ret_base_nxt  = iss_base_r;
    res_found_nxt = res_found_r;
    res_index_nxt = res_index_r;
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_index_nxt = out_index_r;

    if (issue) begin
      iss_w_nxt    = iss_w_r + WCNT_W'(1);
      iss_base_nxt = iss_base_r + BASE_W'(WORD_BITS);
    end

    if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + WCNT_W'(1);
        if (clr_addr_r == WCNT_W'(MAP_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt       = in_cmd.command;
          res_found_nxt = 1'b0;
          res_index_nxt = '0;
          iss_w_nxt     = '0;
          iss_base_nxt  = '0;
          if (in_cmd.command == CMD_ALLOC) begin
            lo_nxt    = '0;
            hi_nxt    = map_x;
            state_nxt = ST_SWEEP;
          end else if ((in_cmd.command == CMD_SET) || (in_cmd.command == CMD_CLR)) begin
            lo_nxt    = in_lo_x;
            hi_nxt    = in_hi_eff;
            state_nxt = (in_lo_x < in_hi_eff) ? ST_SWEEP : ST_FINISH;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_SWEEP: begin
        if (hit) begin
          res_found_nxt = 1'b1;
          res_index_nxt = hit_index[INDEX_W-1:0];
          state_nxt     = ST_FINISH;
        end else if (!issue && !ret_valid_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_index_nxt = res_index_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      ret_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      ret_valid_r <= ret_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    iss_w_r     <= iss_w_nxt;
    iss_base_r  <= iss_base_nxt;
    ret_w_r     <= ret_w_nxt;
    ret_base_r  <= ret_base_nxt;
    res_found_r <= res_found_nxt;
    res_index_r <= res_index_nxt;
    out_found_r <= out_found_nxt;
    out_index_r <= out_index_nxt;
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.found       = out_found_r;
  assign out_res.alloc_index = out_index_r;

  // read and write-back never meet on one word
  a_no_rw_same_word: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("ram read and write hit the same word");

  // returned data only follows a read issued during a sweep
  a_ret_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
    ret_valid_r |-> ($past(state_r) == ST_SWEEP))
    else $error("returned word without a sweep");

  // the map is never written while waiting for commands
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !wr_en)
    else $error("map write while idle");

  // only an allocate reports a claimed bit
  a_found_alloc_only: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && res_found_r) |-> (cmd_r == CMD_ALLOC))
    else $error("found set for a range command");

endmodule
